/* src/best_fit_offset_allocator_unit_defines.svh */
// Assertion macros for the best-fit offset allocator.
// Used by the checker; expects clk_i and rst_ni in the scope of each use.
`ifndef BEST_FIT_OFFSET_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_OFFSET_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BFOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BFOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bfoa_pkg.sv */
// Shared types and constants of the best-fit offset allocator.
// No dependencies; used by the interfaces, the top level and the checker.
package bfoa_pkg;

  // Default sizing
  localparam int unsigned BFOA_FREE_SLOTS = 16;
  localparam int unsigned BFOA_ADDR_BITS  = 32;

  // Fixed field widths
  localparam int unsigned BFOA_DATA_W   = 32;
  localparam int unsigned BFOA_ALIGN_W  = 3;
  localparam int unsigned BFOA_STATUS_W = 2;
  localparam logic [BFOA_ALIGN_W-1:0] BFOA_ALIGN_RST = 3'd3;

  // Request command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bfoa_cmd_e;

  // Response status codes
  typedef enum logic [BFOA_STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TABLE_FULL = 2'd1,
    STATUS_RANGE      = 2'd2
  } bfoa_status_e;

endpackage

/* src/bfoa_if.sv */
// Valid/ready channels of the best-fit offset allocator: request and response.
// Depends on bfoa_pkg for the field widths.
interface bfoa_req_if import bfoa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [BFOA_DATA_W-1:0] req_size;
  logic [BFOA_DATA_W-1:0] free_offset;

  modport source (output valid, command, req_size, free_offset, input ready);
  modport sink   (input valid, command, req_size, free_offset, output ready);
endinterface

interface bfoa_rsp_if import bfoa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BFOA_DATA_W-1:0]   offset;
  logic [BFOA_DATA_W-1:0]   used_bytes;
  logic [BFOA_DATA_W-1:0]   peak_bytes;
  logic [BFOA_STATUS_W-1:0] status;

  modport source (output valid, offset, used_bytes, peak_bytes, status, input ready);
  modport sink   (input valid, offset, used_bytes, peak_bytes, status, output ready);
endinterface

/* src/best_fit_offset_allocator_unit.sv */
// Best-fit offset allocator: top level with sequencer, free table and scan unit.
// Depends on bfoa_pkg and the channel interfaces in bfoa_if.sv.
//
// Usage:
//  - req_i carries one request per handshake: command (alloc/free), req_size and
//    free_offset. rsp_o returns exactly one response per request, in order:
//    offset, used_bytes, peak_bytes and status.
//  - cfg_we_i/cfg_wdata_i write align_log2; write only while the block is idle.
//  - A request with a nonzero aligned size scans the free table one slot per
//    cycle through the table's single read port, then takes a decide/update
//    step, then loads the response register. The next request can be taken
//    once the response register is loaded. A zero-size request skips the
//    scan and the decide/update step and goes straight to loading the
//    response register.
//  - req_i.ready is high only while the sequencer is idle. The response sits
//    in an output register, so a new request is taken while an earlier
//    response still waits; if the receiver stalls, the next response is held
//    in the sequencer until the output register frees.
//  - Reset clears the free-table valid bits, the used and peak counters, and
//    sets the alignment to 8 bytes. No clearing pass is needed.
module best_fit_offset_allocator_unit import bfoa_pkg::*; #(
  parameter int unsigned FREE_SLOTS = BFOA_FREE_SLOTS,
  parameter int unsigned ADDR_BITS  = BFOA_ADDR_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [BFOA_ALIGN_W-1:0] cfg_wdata_i,
  bfoa_req_if.sink                req_i,
  bfoa_rsp_if.source              rsp_o
);

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned IW  = $clog2(FREE_SLOTS);
  localparam int unsigned CW  = $clog2(FREE_SLOTS + 1);
  localparam int unsigned SZW = BFOA_DATA_W + 1;             // aligned size can carry
  localparam int unsigned XW  = ((AW > SZW) ? AW : SZW) + 1; // room for sums vs limit

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Control state
  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    pipe_vld_q, pipe_vld_d;
  logic [IW-1:0]           pipe_idx_q, pipe_idx_d;
  logic [FREE_SLOTS-1:0]   valid_q, valid_d;
  logic [BFOA_DATA_W-1:0]  used_q, used_d;
  logic [AW-1:0]           peak_q, peak_d;
  logic [BFOA_ALIGN_W-1:0] align_q;
  logic                    out_vld_q, out_vld_d;
  logic                    best_fnd_q, best_fnd_d;
  logic                    high_fnd_q, high_fnd_d;
  logic                    emp_fnd_q, emp_fnd_d;

  // Request and scan payload
  logic                    cmd_q, cmd_d;
  logic [SZW-1:0]          sz_q, sz_d;
  logic [BFOA_DATA_W-1:0]  fbeg_q, fbeg_d;
  logic [IW-1:0]           best_idx_q, best_idx_d;
  logic [AW-1:0]           best_beg_q, best_beg_d;
  logic [AW-1:0]           best_len_q, best_len_d;
  logic [IW-1:0]           high_idx_q, high_idx_d;
  logic [AW-1:0]           high_beg_q, high_beg_d;
  logic [XW-1:0]           high_end_q, high_end_d;
  logic [IW-1:0]           emp_idx_q, emp_idx_d;
  logic [AW-1:0]           res_off_q, res_off_d;
  bfoa_status_e            res_stat_q, res_stat_d;

  // Output register payload
  logic [BFOA_DATA_W-1:0]   out_off_q, out_off_d;
  logic [BFOA_DATA_W-1:0]   out_used_q, out_used_d;
  logic [BFOA_DATA_W-1:0]   out_peak_q, out_peak_d;
  logic [BFOA_STATUS_W-1:0] out_stat_q, out_stat_d;

  // Free table memory: {begin, len} per slot
  logic [2*AW-1:0] mem_q [FREE_SLOTS];
  logic [2*AW-1:0] rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [2*AW-1:0] mem_wdata;

  // Scan element and arithmetic
  logic [AW-1:0]  e_beg, e_len;
  logic           e_vld;
  logic [SZW-1:0] align_mask, sz_aligned;
  logic [XW-1:0]  ext_sum, bump_sum, free_sum;
  logic           take;

  assign take        = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.offset     = out_off_q;
  assign rsp_o.used_bytes = out_used_q;
  assign rsp_o.peak_bytes = out_peak_q;
  assign rsp_o.status     = out_stat_q;

  // Round request size up to the alignment
  assign align_mask = (SZW'(1) << align_q) - SZW'(1);
  assign sz_aligned = ({1'b0, req_i.req_size} + align_mask) & ~align_mask;

  assign e_beg = rdata_q[2*AW-1:AW];
  assign e_len = rdata_q[AW-1:0];
  assign e_vld = valid_q[pipe_idx_q];

  // Range sums: a result <= limit when the bits above AW are clear
  assign ext_sum  = XW'(high_beg_q) + XW'(sz_q);
  assign bump_sum = XW'(peak_q) + XW'(sz_q);
  assign free_sum = XW'(fbeg_q) + XW'(sz_q);

  // Sequencer, scan unit and table update
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pipe_vld_d = 1'b0;
    pipe_idx_d = pipe_idx_q;
    valid_d    = valid_q;
    used_d     = used_q;
    peak_d     = peak_q;
    out_vld_d  = out_vld_q;
    best_fnd_d = best_fnd_q;
    high_fnd_d = high_fnd_q;
    emp_fnd_d  = emp_fnd_q;
    cmd_d      = cmd_q;
    sz_d       = sz_q;
    fbeg_d     = fbeg_q;
    best_idx_d = best_idx_q;
    best_beg_d = best_beg_q;
    best_len_d = best_len_q;
    high_idx_d = high_idx_q;
    high_beg_d = high_beg_q;
    high_end_d = high_end_q;
    emp_idx_d  = emp_idx_q;
    res_off_d  = res_off_q;
    res_stat_d = res_stat_q;
    out_off_d  = out_off_q;
    out_used_d = out_used_q;
    out_peak_d = out_peak_q;
    out_stat_d = out_stat_q;
    mem_we     = 1'b0;
    mem_waddr  = best_idx_q;
    mem_wdata  = {best_beg_q, best_len_q};

    // response register drains independently
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_d      = req_i.command;
          sz_d       = sz_aligned;
          fbeg_d     = req_i.free_offset;
          cnt_d      = '0;
          best_fnd_d = 1'b0;
          high_fnd_d = 1'b0;
          emp_fnd_d  = 1'b0;
          res_stat_d = STATUS_OK;
          if (sz_aligned == '0) begin
            // zero size: alloc answers the peak, free is ignored
            res_off_d = (req_i.command == CMD_ALLOC) ? peak_q : '0;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one table read per cycle
        if (cnt_q != CW'(FREE_SLOTS)) begin
          pipe_vld_d = 1'b1;
          pipe_idx_d = cnt_q[IW-1:0];
          cnt_d      = cnt_q + CW'(1);
        end
        // evaluate the slot read last cycle
        if (pipe_vld_q) begin
          if (!e_vld && !emp_fnd_q) begin
            emp_fnd_d = 1'b1;
            emp_idx_d = pipe_idx_q;
          end
          if (e_vld && (XW'(e_len) >= XW'(sz_q)) &&
              (!best_fnd_q || (e_len < best_len_q) ||
               ((e_len == best_len_q) && (e_beg < best_beg_q)))) begin
            best_fnd_d = 1'b1;
            best_idx_d = pipe_idx_q;
            best_beg_d = e_beg;
            best_len_d = e_len;
          end
          if (e_vld && (!high_fnd_q || (e_beg > high_beg_q))) begin
            high_fnd_d = 1'b1;
            high_idx_d = pipe_idx_q;
            high_beg_d = e_beg;
            high_end_d = XW'(e_beg) + XW'(e_len);
          end
          if (cnt_q == CW'(FREE_SLOTS)) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        res_off_d = '0;
        state_d   = ST_FINISH;
        if (cmd_q == CMD_ALLOC) begin
          if (best_fnd_q) begin
            // best fit: take whole block or split its front
            res_off_d = best_beg_q;
            used_d    = used_q + sz_q[BFOA_DATA_W-1:0];
            if (XW'(best_len_q) == XW'(sz_q)) begin
              valid_d[best_idx_q] = 1'b0;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = best_idx_q;
              mem_wdata = {best_beg_q + AW'(sz_q), best_len_q - AW'(sz_q)};
            end
          end else if (high_fnd_q && (high_end_q == XW'(peak_q))) begin
            // top block ends at the peak: extend it
            if (ext_sum[XW-1:AW] == '0) begin
              res_off_d           = high_beg_q;
              valid_d[high_idx_q] = 1'b0;
              peak_d              = ext_sum[AW-1:0];
              used_d              = used_q + sz_q[BFOA_DATA_W-1:0];
            end else begin
              res_stat_d = STATUS_RANGE;
            end
          end else if (bump_sum[XW-1:AW] == '0) begin
            // bump at the peak
            res_off_d = peak_q;
            peak_d    = bump_sum[AW-1:0];
            used_d    = used_q + sz_q[BFOA_DATA_W-1:0];
          end else begin
            res_stat_d = STATUS_RANGE;
          end
        end else begin
          if (free_sum[XW-1:AW] != '0) begin
            res_stat_d = STATUS_RANGE;
          end else begin
            used_d = used_q - sz_q[BFOA_DATA_W-1:0];
            if (!emp_fnd_q) begin
              res_stat_d = STATUS_TABLE_FULL;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = emp_idx_q;
              mem_wdata          = {AW'(fbeg_q), AW'(sz_q)};
              valid_d[emp_idx_q] = 1'b1;
            end
          end
        end
      end

      ST_FINISH: begin
        // load the response once the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d  = 1'b1;
          out_off_d  = BFOA_DATA_W'(res_off_q);
          out_used_d = used_q;
          out_peak_d = BFOA_DATA_W'(peak_q);
          out_stat_d = res_stat_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
      valid_q    <= '0;
      used_q     <= '0;
      peak_q     <= '0;
      align_q    <= BFOA_ALIGN_RST;
      out_vld_q  <= 1'b0;
      best_fnd_q <= 1'b0;
      high_fnd_q <= 1'b0;
      emp_fnd_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pipe_vld_q <= pipe_vld_d;
      valid_q    <= valid_d;
      used_q     <= used_d;
      peak_q     <= peak_d;
      out_vld_q  <= out_vld_d;
      best_fnd_q <= best_fnd_d;
      high_fnd_q <= high_fnd_d;
      emp_fnd_q  <= emp_fnd_d;
      if (cfg_we_i) begin
        align_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    cmd_q      <= cmd_d;
    sz_q       <= sz_d;
    fbeg_q     <= fbeg_d;
    best_idx_q <= best_idx_d;
    best_beg_q <= best_beg_d;
    best_len_q <= best_len_d;
    high_idx_q <= high_idx_d;
    high_beg_q <= high_beg_d;
    high_end_q <= high_end_d;
    emp_idx_q  <= emp_idx_d;
    res_off_q  <= res_off_d;
    res_stat_q <= res_stat_d;
    out_off_q  <= out_off_d;
    out_used_q <= out_used_d;
    out_peak_q <= out_peak_d;
    out_stat_q <= out_stat_d;
  end

  // Free table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[cnt_q[IW-1:0]];
  end

endmodule

/* src/bfoa_checker.sv */
// Port-level checker for the best-fit offset allocator, bound to the top level.
// Depends on bfoa_pkg and best_fit_offset_allocator_unit_defines.svh.
`include "best_fit_offset_allocator_unit_defines.svh"

module bfoa_checker import bfoa_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     req_valid_i,
  input logic                     req_ready_i,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic [BFOA_DATA_W-1:0]   rsp_offset_i,
  input logic [BFOA_DATA_W-1:0]   rsp_used_i,
  input logic [BFOA_DATA_W-1:0]   rsp_peak_i,
  input logic [BFOA_STATUS_W-1:0] rsp_status_i
);

  logic       req_acc, rsp_acc;
  logic [1:0] pend_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_acc && !rsp_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // sequencer goes busy right after taking a request
  `BFOA_ASSERT_NEXT(a_busy_after_req, req_acc, !req_ready_i, "ready after request taken")

  // no response without an outstanding request, at most one waiting at intake
  `BFOA_ASSERT_SAME(a_no_extra_rsp, rsp_valid_i, pend_q != 2'd0, "response without request")
  `BFOA_ASSERT_SAME(a_pend_bound, req_acc, pend_q <= 2'd1, "too many requests in flight")

  // range failures give no offset
  `BFOA_ASSERT_SAME(a_range_zero_off, rsp_valid_i && (rsp_status_i == STATUS_RANGE), rsp_offset_i == '0, "offset on range failure")

  // stalled response holds
  `BFOA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_offset_i) && $stable(rsp_used_i) && $stable(rsp_peak_i) && $stable(rsp_status_i), "stalled response changed")

endmodule

bind best_fit_offset_allocator_unit bfoa_checker u_bfoa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_offset_i (rsp_o.offset),
  .rsp_used_i   (rsp_o.used_bytes),
  .rsp_peak_i   (rsp_o.peak_bytes),
  .rsp_status_i (rsp_o.status)
);
